// ===== sv/abrc_pkg.sv =====
package abrc_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	typedef enum logic [2:0] {
		REG_RECT_LEFT    = 3'd0,
		REG_RECT_TOP     = 3'd1,
		REG_RECT_COLUMNS = 3'd2,
		REG_RECT_ROWS    = 3'd3,
		REG_FILL_ARGB    = 3'd4,
		REG_IMAGE_MODE   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] source_argb;
		logic [31:0] dest_argb;
	} blit_req_t;

	typedef struct packed {
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [31:0] pixel_argb;
		logic        last_of_rect;
	} blit_res_t;

endpackage

// ===== sv/abrc_blend.sv =====
module abrc_blend (
	input  logic [31:0] src_argb,
	input  logic [31:0] dst_argb,
	output logic [31:0] pixel_argb
);
	import abrc_pkg::*;

	logic [7:0] alpha;
	logic [7:0] inv_alpha;
	logic [7:0] mix [3];

	assign alpha     = src_argb[31:24];
	assign inv_alpha = ALPHA_OPAQUE - alpha;

	// per channel: (dst*(255-a) + src*a) >> 8, sum fits in 17 bits
	always_comb begin
		logic [16:0] acc;
		for (int c = 0; c < 3; c++) begin
			acc = 17'({9'd0, dst_argb[8*c +: 8]} * {9'd0, inv_alpha})
				+ 17'({9'd0, src_argb[8*c +: 8]} * {9'd0, alpha});
			mix[c] = acc[15:8];
		end
	end

	always_comb begin
		if (alpha == ALPHA_OPAQUE) begin
			pixel_argb = src_argb;
		end else begin
			pixel_argb = {ALPHA_OPAQUE, mix[2], mix[1], mix[0]};
		end
	end

endmodule

// ===== sv/alpha_blend_rect_compositor_core.sv =====
// channel   | handshake              | payload            | direction
// ----------+------------------------+--------------------+----------
// blit      | blit_valid, blit_ready | blit (blit_req_t)  | in
// res       | res_valid, res_ready   | res (blit_res_t)   | out
// apb       | psel, penable, pwrite  | paddr, pwdata      | in / prdata out
//
// one pixel request per clock while blit_ready is high; a taken request is registered in _s1, then in _s2
// the rate is set by the two-stage pipe: input stage _s1, result stage _s2
// arst_n clears the stage valids, the counters and the configuration registers to zero
// a stalled result holds in _s2 while _s1 still takes one more request
// requests into an empty rectangle are taken and give no result
module alpha_blend_rect_compositor_core #(
	parameter int unsigned COORD_BITS = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// pixel requests
	input  logic                          blit_valid,
	output logic                          blit_ready,
	input  abrc_pkg::blit_req_t           blit,
	// results
	output logic                          res_valid,
	input  logic                          res_ready,
	output abrc_pkg::blit_res_t           res,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [abrc_pkg::ADDR_W-1:0]   paddr,
	input  logic [abrc_pkg::DATA_W-1:0]   pwdata,
	output logic [abrc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import abrc_pkg::*;

	// compare width: holds the extent 2^COORD_BITS and the 12-bit register
	localparam int unsigned XW    = (COORD_BITS > 12) ? COORD_BITS : 12;
	localparam int unsigned CMP_W = XW + 1;
	localparam logic [CMP_W-1:0] EXTENT_MAX = CMP_W'(1) << COORD_BITS;

	// configuration registers
	logic [10:0] rect_left_q;
	logic [10:0] rect_top_q;
	logic [11:0] rect_columns_q;
	logic [11:0] rect_rows_q;
	logic [31:0] fill_argb_q;
	logic        image_mode_q;

	// raster counters
	logic [COORD_BITS-1:0] column_count_q;
	logic [COORD_BITS-1:0] row_count_q;

	// pipe stages
	logic        valid_s1;
	logic [31:0] src_s1;
	logic [31:0] dst_s1;
	logic [11:0] x_s1;
	logic [11:0] y_s1;
	logic        last_s1;
	logic        valid_s2;
	blit_res_t   res_s2;

	logic        cfg_wr;
	reg_idx_t    cfg_idx;
	logic        take;
	logic        advance;
	logic [CMP_W-1:0] cols;
	logic [CMP_W-1:0] rows;
	logic [CMP_W-1:0] col_ext;
	logic [CMP_W-1:0] row_ext;
	logic        rect_empty;
	logic        end_col;
	logic        end_row;
	logic [31:0] blended;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_left_q    <= '0;
			rect_top_q     <= '0;
			rect_columns_q <= '0;
			rect_rows_q    <= '0;
			fill_argb_q    <= '0;
			image_mode_q   <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_RECT_LEFT:    rect_left_q    <= pwdata[10:0];
				REG_RECT_TOP:     rect_top_q     <= pwdata[10:0];
				REG_RECT_COLUMNS: rect_columns_q <= pwdata[11:0];
				REG_RECT_ROWS:    rect_rows_q    <= pwdata[11:0];
				REG_FILL_ARGB:    fill_argb_q    <= pwdata;
				REG_IMAGE_MODE:   image_mode_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (cfg_idx)
			REG_RECT_LEFT:    prdata = {21'd0, rect_left_q};
			REG_RECT_TOP:     prdata = {21'd0, rect_top_q};
			REG_RECT_COLUMNS: prdata = {20'd0, rect_columns_q};
			REG_RECT_ROWS:    prdata = {20'd0, rect_rows_q};
			REG_FILL_ARGB:    prdata = fill_argb_q;
			REG_IMAGE_MODE:   prdata = {31'd0, image_mode_q};
			default:          prdata = '0;
		endcase
	end

	// extents above 2^COORD_BITS clamp to it
	always_comb begin
		cols = CMP_W'(rect_columns_q);
		rows = CMP_W'(rect_rows_q);
		if (cols > EXTENT_MAX) begin
			cols = EXTENT_MAX;
		end
		if (rows > EXTENT_MAX) begin
			rows = EXTENT_MAX;
		end
	end

	assign rect_empty = (cols == '0) || (rows == '0);
	assign col_ext    = CMP_W'(column_count_q);
	assign row_ext    = CMP_W'(row_count_q);
	assign end_col    = (col_ext + CMP_W'(1)) >= cols;
	assign end_row    = (row_ext + CMP_W'(1)) >= rows;

	// handshake: the result stage frees the input stage
	assign advance    = !valid_s2 || res_ready;
	assign blit_ready = !valid_s1 || advance;
	assign take       = blit_valid && blit_ready;

	// counters step on every request into a non-empty rectangle;
	// any listed register write restarts the rectangle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (cfg_wr && (cfg_idx inside {REG_RECT_LEFT, REG_RECT_TOP,
				REG_RECT_COLUMNS, REG_RECT_ROWS, REG_FILL_ARGB, REG_IMAGE_MODE})) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (take && !rect_empty) begin
			if (end_col) begin
				column_count_q <= '0;
				row_count_q    <= end_row ? '0 : row_count_q + 1'b1;
			end else begin
				column_count_q <= column_count_q + 1'b1;
			end
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (blit_ready) begin
			valid_s1 <= blit_valid && !rect_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			src_s1  <= image_mode_q ? blit.source_argb : fill_argb_q;
			dst_s1  <= blit.dest_argb;
			x_s1    <= 12'(CMP_W'(rect_left_q) + col_ext);
			y_s1    <= 12'(CMP_W'(rect_top_q) + row_ext);
			last_s1 <= end_col && end_row;
		end
	end

	abrc_blend u_blend (
		.src_argb   (src_s1),
		.dst_argb   (dst_s1),
		.pixel_argb (blended)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2.pixel_x      <= x_s1;
			res_s2.pixel_y      <= y_s1;
			res_s2.pixel_argb   <= blended;
			res_s2.last_of_rect <= last_s1;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

endmodule

// ===== sv/abrc_checker.sv =====
module abrc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                blit_valid,
	input logic                blit_ready,
	input logic                res_valid,
	input logic                res_ready,
	input abrc_pkg::blit_res_t res,
	input logic                pready
);
	import abrc_pkg::*;

	// a waiting result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// every written pixel is opaque
	a_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.pixel_argb[31:24] == ALPHA_OPAQUE)
		else $error("result alpha not opaque");

	// requests back up only behind a full, stalled result stage
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!blit_ready |-> res_valid && !res_ready && pready)
		else $error("request stalled without a stalled result");

	// a fresh result has passed the input stage and the result stage since its request was taken
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(blit_valid && blit_ready, 2))
		else $error("result without a matching request");

endmodule

bind alpha_blend_rect_compositor_core abrc_checker u_abrc_checker (.*);

// ===== test/alpha_blend_rect_compositor_core_test.sv =====
module alpha_blend_rect_compositor_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import abrc_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PIXELS = 150;
	// a request passes the input stage before it reaches the result stage
	localparam int DRAIN_CYCLES  = 4;
	localparam int LONG_HOLD     = 300;
	localparam int EXTENT_MAX    = 2048;
	// first address past the register list, writes there must change nothing
	localparam logic [2:0] REG_SPARE = 3'd6;

	// tracks the register file and the raster counters, queues one expected
	// output pixel per request taken inside a non-empty rectangle
	class blend_scoreboard;
		logic [10:0] left = '0;
		logic [10:0] top = '0;
		logic [11:0] columns = '0;
		logic [11:0] rows = '0;
		logic [31:0] fill = '0;
		logic        image = 1'b0;
		logic [10:0] col_cnt = '0;
		logic [10:0] row_cnt = '0;
		blit_res_t   pending_pixels[$];
		int          errors = 0;

		function int pending();
			return pending_pixels.size();
		endfunction

		function void apply_write(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_RECT_LEFT:    left = v[10:0];
				REG_RECT_TOP:     top = v[10:0];
				REG_RECT_COLUMNS: columns = v[11:0];
				REG_RECT_ROWS:    rows = v[11:0];
				REG_FILL_ARGB:    fill = v;
				REG_IMAGE_MODE:   image = v[0];
				default:          return;
			endcase
			col_cnt = '0;
			row_cnt = '0;
		endfunction

		function logic [31:0] blend_pixel(logic [31:0] dst, logic [31:0] src);
			int unsigned alpha;
			int unsigned d;
			int unsigned s;
			int unsigned v;
			logic [31:0] mixed;
			alpha = src[31:24];
			if (src[31:24] == ALPHA_OPAQUE)
				return src;
			mixed = {ALPHA_OPAQUE, 24'h0};
			for (int sh = 0; sh < 24; sh += 8) begin
				d = (dst >> sh) & 32'hFF;
				s = (src >> sh) & 32'hFF;
				v = (d * (int'(ALPHA_OPAQUE) - alpha) + s * alpha) >> 8;
				mixed[sh +: 8] = v[7:0];
			end
			return mixed;
		endfunction

		function void note_request(blit_req_t r);
			int unsigned cols;
			int unsigned nrows;
			logic        end_col;
			logic        end_row;
			blit_res_t   e;
			cols = (columns > EXTENT_MAX) ? EXTENT_MAX : columns;
			nrows = (rows > EXTENT_MAX) ? EXTENT_MAX : rows;
			if (cols == 0 || nrows == 0)
				return;
			end_col = (int'(col_cnt) + 1 >= cols);
			end_row = (int'(row_cnt) + 1 >= nrows);
			e.pixel_x = {1'b0, left} + {1'b0, col_cnt};
			e.pixel_y = {1'b0, top} + {1'b0, row_cnt};
			e.pixel_argb = blend_pixel(r.dest_argb, image ? r.source_argb : fill);
			e.last_of_rect = end_col && end_row;
			pending_pixels.push_back(e);
			if (end_col) begin
				col_cnt = '0;
				row_cnt = end_row ? '0 : row_cnt + 1'b1;
			end else begin
				col_cnt = col_cnt + 1'b1;
			end
		endfunction

		function void check_result(blit_res_t got);
			blit_res_t e;
			if (pending_pixels.size() == 0) begin
				$error("result with no request waiting: x %0d y %0d argb %h",
					got.pixel_x, got.pixel_y, got.pixel_argb);
				errors++;
				return;
			end
			e = pending_pixels.pop_front();
			if (got.pixel_x !== e.pixel_x) begin
				$error("pixel_x: expected %0d, got %0d", e.pixel_x, got.pixel_x);
				errors++;
			end
			if (got.pixel_y !== e.pixel_y) begin
				$error("pixel_y: expected %0d, got %0d", e.pixel_y, got.pixel_y);
				errors++;
			end
			if (got.pixel_argb !== e.pixel_argb) begin
				$error("pixel_argb: expected %h, got %h", e.pixel_argb, got.pixel_argb);
				errors++;
			end
			if (got.last_of_rect !== e.last_of_rect) begin
				$error("last_of_rect: expected %b, got %b", e.last_of_rect, got.last_of_rect);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                blit_valid;
	logic                blit_ready;
	blit_req_t           blit;
	logic                res_valid;
	logic                res_ready;
	blit_res_t           res;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	blend_scoreboard pixel_sb = new();
	int unsigned     cycle_count = 0;
	// requests left in the current sender burst
	int              burst_left = 0;
	// set by the stimulus, picked up and counted down by the receiver
	int              hold_request = 0;

	alpha_blend_rect_compositor_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.blit_valid (blit_valid),
		.blit_ready (blit_ready),
		.blit       (blit),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// watchdog, far above the slowest legal run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("alpha_blend_rect_compositor_core_test NOT OK");
			$finish;
		end
	end

	// both handshakes are sampled on the rising edge, before the block updates
	always @(posedge clk) begin
		if (arst_n) begin
			if (blit_valid && blit_ready)
				pixel_sb.note_request(blit);
			if (res_valid && res_ready)
				pixel_sb.check_result(res);
		end
	end

	// receiver: picks a new stall pattern whenever the current one runs out, from always
	// ready to coin flips to rare short stalls; a long hold can be injected
	initial begin : receiver
		int mode;
		int mode_left;
		int stall_left;
		mode = 0;
		mode_left = 0;
		stall_left = 0;
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			if (stall_left != 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else if (mode == 0) begin
				res_ready <= 1'b1;
			end else if (mode == 1) begin
				res_ready <= 1'($urandom_range(0, 1));
			end else if ($urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 7);
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// setup then access phase write, the register takes the value on the access edge
	task automatic apb_write(input logic [2:0] idx, input logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		pixel_sb.apply_write(idx, v);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// offers one pixel request; bursts of random length with random gaps
	task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
			if (gap != 0) begin
				@(negedge clk);
				blit_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		blit_valid <= 1'b1;
		blit <= '{source_argb: src, dest_argb: dst};
		@(posedge clk);
		while (!blit_ready)
			@(posedge clk);
	endtask

	// sender stops until every pixel is back and the pipe has emptied
	task automatic wait_quiet();
		@(negedge clk);
		blit_valid <= 1'b0;
		burst_left = 0;
		while (pixel_sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// alpha leans toward opaque, transparent and the values next to them
	function automatic logic [31:0] random_argb();
		logic [31:0] v;
		v = $urandom();
		case ($urandom_range(0, 7))
			0, 1: v[31:24] = ALPHA_OPAQUE;
			2:    v[31:24] = 8'h00;
			3:    v[31:24] = 8'hFE;
			4:    v[31:24] = 8'h01;
			default: ;
		endcase
		return v;
	endfunction

	task automatic run_pixels(input int n);
		for (int i = 0; i < n; i++)
			send_pixel(random_argb(), $urandom());
	endtask

	function automatic logic [31:0] pick_corner();
		case ($urandom_range(0, 3))
			0:       return 32'd0;
			1:       return 32'd2047;
			default: return $urandom_range(0, 2047);
		endcase
	endfunction

	function automatic logic [31:0] pick_extent();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 32'd0;
		if (r == 1)
			return $urandom_range(17, 64);
		return $urandom_range(1, 16);
	endfunction

	// random subset of registers, every write restarts the raster
	task automatic random_setup();
		if ($urandom_range(0, 1))
			apb_write(REG_RECT_LEFT, pick_corner());
		if ($urandom_range(0, 1))
			apb_write(REG_RECT_TOP, pick_corner());
		if ($urandom_range(0, 2) != 0)
			apb_write(REG_RECT_COLUMNS, pick_extent());
		if ($urandom_range(0, 2) != 0)
			apb_write(REG_RECT_ROWS, pick_extent());
		if ($urandom_range(0, 1))
			apb_write(REG_FILL_ARGB, random_argb());
		if ($urandom_range(0, 1))
			apb_write(REG_IMAGE_MODE, $urandom_range(0, 1));
	endtask

	initial begin : stimulus
		int pixels_sent;
		int cols;
		int nrows;
		int n;
		pixels_sent = 0;
		arst_n = 1'b0;
		blit_valid = 1'b0;
		blit = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty rectangle out of reset, requests vanish
		send_pixel(32'hFFFFFFFF, 32'h00000000);
		send_pixel(32'h00000000, 32'hFFFFFFFF);
		send_pixel(32'h80808080, 32'h7F7F7F7F);
		wait_quiet();

		// opaque fill at the far corner, full 3x2 rectangle then a wrap
		apb_write(REG_RECT_LEFT, 32'd2047);
		apb_write(REG_RECT_TOP, 32'd2047);
		apb_write(REG_RECT_COLUMNS, 32'd3);
		apb_write(REG_RECT_ROWS, 32'd2);
		apb_write(REG_FILL_ARGB, 32'hFF123456);
		apb_write(REG_IMAGE_MODE, 32'd0);
		send_pixel(32'h00000000, 32'h00000000);
		send_pixel(32'hFFFFFFFF, 32'hFFFFFFFF);
		send_pixel(32'h12345678, 32'h87654321);
		send_pixel(32'h00000000, 32'hA5A5A5A5);
		send_pixel(32'hFFFFFFFF, 32'h5A5A5A5A);
		send_pixel(32'h0F0F0F0F, 32'hF0F0F0F0);
		send_pixel(32'hDEADBEEF, 32'h01020304);
		wait_quiet();

		// transparent fill: destination wins, alpha forced opaque
		apb_write(REG_FILL_ARGB, 32'h00ABCDEF);
		send_pixel(32'hFFFFFFFF, 32'hFFFFFFFF);
		send_pixel(32'hFFFFFFFF, 32'h00000000);
		wait_quiet();

		// half alpha fill against both destination extremes
		apb_write(REG_FILL_ARGB, 32'h80FF00FF);
		send_pixel(32'h00000000, 32'h00000000);
		send_pixel(32'h00000000, 32'hFFFFFFFF);
		wait_quiet();

		// image source on a single pixel rectangle, every request is the last
		apb_write(REG_IMAGE_MODE, 32'd1);
		apb_write(REG_RECT_LEFT, 32'd0);
		apb_write(REG_RECT_TOP, 32'd0);
		apb_write(REG_RECT_COLUMNS, 32'd1);
		apb_write(REG_RECT_ROWS, 32'd1);
		send_pixel(32'hFF00FF00, 32'h12345678);
		send_pixel(32'h00FFFFFF, 32'hFFFFFFFF);
		send_pixel(32'h7F80C0FF, 32'h00000000);
		send_pixel(32'hFFFFFFFF, 32'h00000000);
		send_pixel(32'h00000000, 32'hFFFFFFFF);
		send_pixel(32'hFE000000, 32'h00FFFFFF);
		wait_quiet();

		// write past the register list mid row, raster must carry on
		apb_write(REG_RECT_COLUMNS, 32'd4);
		send_pixel(random_argb(), $urandom());
		send_pixel(random_argb(), $urandom());
		wait_quiet();
		apb_write(REG_SPARE, 32'hFFFFFFFF);
		send_pixel(random_argb(), $urandom());
		send_pixel(random_argb(), $urandom());
		wait_quiet();

		// long receiver hold while requests keep coming, fills the pipe
		apb_write(REG_RECT_COLUMNS, 32'd7);
		apb_write(REG_RECT_ROWS, 32'd5);
		hold_request = LONG_HOLD;
		run_pixels(80);
		wait_quiet();

		// tallest rectangle, only the top rows
		apb_write(REG_RECT_COLUMNS, 32'd1);
		apb_write(REG_RECT_ROWS, 32'd2048);
		apb_write(REG_RECT_TOP, 32'd2047);
		run_pixels(60);
		wait_quiet();

		// width beyond the limit clamps to full width, run past the wrap
		apb_write(REG_RECT_LEFT, 32'd2047);
		apb_write(REG_RECT_TOP, 32'd0);
		apb_write(REG_RECT_COLUMNS, 32'd4095);
		apb_write(REG_RECT_ROWS, 32'd1);
		run_pixels(EXTENT_MAX + 4);
		wait_quiet();

		// random rectangles, mostly small, usually run to the end and past it
		while (pixels_sent < RANDOM_PIXELS) begin
			random_setup();
			cols = (pixel_sb.columns > EXTENT_MAX) ? EXTENT_MAX : pixel_sb.columns;
			nrows = (pixel_sb.rows > EXTENT_MAX) ? EXTENT_MAX : pixel_sb.rows;
			if (cols == 0 || nrows == 0) begin
				run_pixels(3);
			end else begin
				n = cols * nrows * $urandom_range(1, 2) + $urandom_range(0, cols);
				if (n > 150)
					n = 150;
				run_pixels(n);
				pixels_sent += n;
			end
			wait_quiet();
		end

		repeat (2 * DRAIN_CYCLES) @(posedge clk);
		if (pixel_sb.errors == 0 && pixel_sb.pending() == 0)
			$display("alpha_blend_rect_compositor_core_test OK");
		else
			$display("alpha_blend_rect_compositor_core_test NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/abrc_pkg.sv
sv/abrc_blend.sv
sv/alpha_blend_rect_compositor_core.sv
sv/abrc_checker.sv
test/alpha_blend_rect_compositor_core_test.sv
